// ===== src/see_pkg.sv =====
package see_pkg;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_ESCAPE_STYLE = 3'h0;

    // Escape styles
    localparam logic STYLE_C    = 1'b0;
    localparam logic STYLE_JSON = 1'b1;

    // Longest expansion of one input byte
    localparam int MAX_OUT = 6;
    localparam int LEN_W   = 3;

    // Fixed characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] NO_ESCAPE = 8'h00;

    // One expanded input byte, waiting to go out a byte per beat
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] text;
        logic [LEN_W-1:0]        len;
        logic                    fin;
        logic                    trunc;
    } see_desc_t;

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'(8'h30 + {4'h0, nib}) : 8'(8'h57 + {4'h0, nib});
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'(8'h30 + {4'h0, nib}) : 8'(8'h37 + {4'h0, nib});
    endfunction

    function automatic logic [7:0] c_escape(input logic [7:0] b);
        logic [7:0] e;
        case (b)
            8'h08: e = "b";
            8'h0C: e = "f";
            8'h0A: e = "n";
            8'h0D: e = "r";
            8'h07: e = "a";
            8'h09: e = "t";
            8'h0B: e = "v";
            8'h27: e = "'";
            8'h22: e = "\"";
            8'h5C: e = "\\";
            default: e = NO_ESCAPE;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] json_escape(input logic [7:0] b);
        logic [7:0] e;
        case (b)
            8'h08: e = "b";
            8'h0C: e = "f";
            8'h0A: e = "n";
            8'h0D: e = "r";
            8'h09: e = "t";
            8'h5C: e = "\\";
            8'h2F: e = "/";
            8'h22: e = "\"";
            default: e = NO_ESCAPE;
        endcase
        return e;
    endfunction

    // Count of leading ones of a UTF-8 lead byte, 0 to 8
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            run = run & b[i];
            n   = n + {3'b000, run};
        end
        return n;
    endfunction

    // Build a \uXXXX sequence in lower-case hex
    function automatic see_desc_t u16_desc(input logic [15:0] v, input logic trunc);
        see_desc_t d;
        d       = '0;
        d.text[0] = CH_BSLASH;
        d.text[1] = CH_U;
        d.text[2] = hex_lower(v[15:12]);
        d.text[3] = hex_lower(v[11:8]);
        d.text[4] = hex_lower(v[7:4]);
        d.text[5] = hex_lower(v[3:0]);
        d.len   = LEN_W'(MAX_OUT);
        d.trunc = trunc;
        return d;
    endfunction

endpackage

// ===== src/string_escape_encoder.sv =====
// An accepted input beat goes through the holding and emit registers to its first output
// byte. Throughput: one input beat per cycle while each expands to one byte and m_ready
// is high; otherwise the one-byte output channel sets the pace (up to 6 bytes per item).
// A holding register parts input and output, so an item is taken while another drains.
// Reset (aresetn low, synchronous) clears the UTF-8 collection state, empties both
// stages and selects C-style escaping.
module string_escape_encoder import see_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input bytes
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  logic                  s_string_end,
    // escaped bytes
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_run_last,
    output logic                  m_string_done,
    output logic                  m_truncated_utf8
);

    logic             style_reg;
    logic [2:0]       pend_reg, pend_next;
    logic [15:0]      acc_reg, acc_next;
    logic             hold_valid_reg, hold_valid_next;
    see_desc_t        hold_desc_reg, hold_desc_next;
    logic             emit_valid_reg, emit_valid_next;
    see_desc_t        emit_desc_reg, emit_desc_next;
    logic [LEN_W-1:0] emit_idx_reg, emit_idx_next;

    see_desc_t        new_desc;
    logic             new_has;
    logic             s_accept;
    logic             emit_last;
    logic             emit_take;
    logic             emit_free;
    logic [15:0]      acc_shift;
    logic [2:0]       pend_dec;
    logic [3:0]       ones;
    logic [7:0]       lead_val;
    logic [7:0]       esc;

    // Register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_ESCAPE_STYLE[2]) ?
                    {{(APB_DATA_W-1){1'b0}}, style_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            style_reg <= STYLE_C;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ADDR_ESCAPE_STYLE[2]) begin
            style_reg <= pwdata[0];
        end
    end

    // Handshakes
    assign emit_last = (emit_idx_reg == LEN_W'(emit_desc_reg.len - LEN_W'(1)));
    assign emit_take = emit_valid_reg && m_ready && emit_last;
    assign emit_free = !emit_valid_reg || emit_take;
    assign s_ready   = !hold_valid_reg || emit_free;
    assign s_accept  = s_valid && s_ready;

    // Expand the incoming byte and advance the UTF-8 state
    always_comb begin
        acc_shift = {acc_reg[9:0], s_in_byte[5:0]};
        pend_dec  = pend_reg - 3'd1;
        ones      = lead_ones(s_in_byte);
        lead_val  = (ones == 4'd8) ? s_in_byte : (s_in_byte & (8'hFF >> (ones + 4'd1)));
        esc       = (style_reg == STYLE_C) ? c_escape(s_in_byte) : json_escape(s_in_byte);
        new_desc  = '0;
        new_has   = 1'b0;
        pend_next = pend_reg;
        acc_next  = acc_reg;

        if (pend_reg != 3'd0) begin
            pend_next = pend_dec;
            acc_next  = acc_shift;
            if (pend_dec == 3'd0) begin
                new_desc = u16_desc(acc_shift, 1'b0);
                new_has  = 1'b1;
                acc_next = '0;
            end else if (s_string_end) begin
                new_desc  = u16_desc(16'hFFFF, 1'b1);
                new_has   = 1'b1;
                pend_next = '0;
                acc_next  = '0;
            end
        end else if (esc != NO_ESCAPE) begin
            new_desc.text[0] = CH_BSLASH;
            new_desc.text[1] = esc;
            new_desc.len     = LEN_W'(2);
            new_has          = 1'b1;
        end else if (style_reg == STYLE_C) begin
            new_has = 1'b1;
            if (s_in_byte < 8'h20 || s_in_byte > 8'h7E) begin
                new_desc.text[0] = CH_BSLASH;
                new_desc.text[1] = CH_ZERO;
                new_desc.text[2] = CH_X;
                new_desc.text[3] = hex_upper(s_in_byte[7:4]);
                new_desc.text[4] = hex_upper(s_in_byte[3:0]);
                new_desc.len     = LEN_W'(5);
            end else begin
                new_desc.text[0] = s_in_byte;
                new_desc.len     = LEN_W'(1);
            end
        end else if (s_in_byte[7]) begin
            if (ones <= 4'd1) begin
                new_desc = u16_desc({8'h00, lead_val}, 1'b0);
                new_has  = 1'b1;
            end else if (s_string_end) begin
                new_desc = u16_desc(16'hFFFF, 1'b1);
                new_has  = 1'b1;
            end else begin
                pend_next = 3'(ones - 4'd1);
                acc_next  = {8'h00, lead_val};
            end
        end else if (s_in_byte < 8'h20 || s_in_byte >= 8'h7E) begin
            new_desc = u16_desc({8'h00, s_in_byte}, 1'b0);
            new_has  = 1'b1;
        end else begin
            new_desc.text[0] = s_in_byte;
            new_desc.len     = LEN_W'(1);
            new_has          = 1'b1;
        end
        new_desc.fin = s_string_end;
    end

    // Hold one expanded item; hand it to the emitter when that frees up
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_desc_next  = hold_desc_reg;
        emit_valid_next = emit_valid_reg;
        emit_desc_next  = emit_desc_reg;
        emit_idx_next   = emit_idx_reg;

        if (s_accept && new_has) begin
            hold_valid_next = 1'b1;
            hold_desc_next  = new_desc;
        end else if (hold_valid_reg && emit_free) begin
            hold_valid_next = 1'b0;
        end

        if (emit_free) begin
            emit_valid_next = hold_valid_reg;
            emit_desc_next  = hold_desc_reg;
            emit_idx_next   = '0;
        end else if (emit_valid_reg && m_ready) begin
            emit_idx_next = emit_idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg       <= '0;
            acc_reg        <= '0;
            hold_valid_reg <= 1'b0;
            emit_valid_reg <= 1'b0;
            emit_idx_reg   <= '0;
        end else begin
            if (s_accept) begin
                pend_reg <= pend_next;
                acc_reg  <= acc_next;
            end
            hold_valid_reg <= hold_valid_next;
            emit_valid_reg <= emit_valid_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        hold_desc_reg <= hold_desc_next;
        emit_desc_reg <= emit_desc_next;
    end

    // Drive the output beat
    assign m_valid          = emit_valid_reg;
    assign m_out_byte       = emit_desc_reg.text[emit_idx_reg];
    assign m_run_last       = emit_last;
    assign m_string_done    = emit_last && emit_desc_reg.fin;
    assign m_truncated_utf8 = emit_desc_reg.trunc;

endmodule

// ===== src/see_checker.sv =====
module see_checker import see_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [7:0]            m_out_byte,
    input logic                  m_run_last,
    input logic                  m_string_done,
    input logic                  m_truncated_utf8
);

    // Stalled output beat holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
        && $stable(m_run_last) && $stable(m_string_done))
        else $error("output beat changed while stalled");

    // End of string falls only on the last byte of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_done |-> m_run_last)
        else $error("string_done without run_last");

    // A cut sequence only appears at the end of a string and ends in 'f'
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated_utf8 && m_run_last |-> m_string_done
        && m_out_byte == CH_LOWER_F)
        else $error("truncated sequence not closing the string");

    // Reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind string_escape_encoder see_checker u_see_checker (.*);
